// ===== rtl/scp_pkg.sv =====
// Shared widths, payload structs and constants for the segment closest points unit.
package scp_pkg;

    // Coordinate width (signed Q16.16) and the derived internal widths
    localparam int CW    = 32;
    localparam int THR_W = 32;
    localparam int DV    = CW + 1;          // endpoint differences
    localparam int DOT_W = 2 * DV + 2;      // dot product of two difference vectors
    localparam int PF    = 32;              // fraction bits of the segment parameters
    localparam int WA    = 2 * DOT_W + 1;   // first divider operands
    localparam int WB    = DOT_W + PF + 3;  // second divider operands
    localparam int ACC_W = DV + PF + 4;     // output accumulator

    localparam logic [PF:0] PAR_ONE = {1'b1, {PF{1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] p_start_x;
        logic signed [CW-1:0] p_start_y;
        logic signed [CW-1:0] p_start_z;
        logic signed [CW-1:0] p_end_x;
        logic signed [CW-1:0] p_end_y;
        logic signed [CW-1:0] p_end_z;
        logic signed [CW-1:0] q_start_x;
        logic signed [CW-1:0] q_start_y;
        logic signed [CW-1:0] q_start_z;
        logic signed [CW-1:0] q_end_x;
        logic signed [CW-1:0] q_end_y;
        logic signed [CW-1:0] q_end_z;
    } t_seg_in;

    typedef struct packed {
        logic signed [CW-1:0] diff_x;
        logic signed [CW-1:0] diff_y;
        logic signed [CW-1:0] diff_z;
        logic                 both_degenerate;
    } t_seg_out;

    // Classified segment pair handed from front to back
    typedef struct packed {
        logic [2:0][CW-1:0]      ps;
        logic [2:0][DV-1:0]      r;
        logic [2:0][DV-1:0]      d1;
        logic [2:0][DV-1:0]      d2;
        logic signed [DOT_W-1:0] a;
        logic signed [DOT_W-1:0] e;
        logic signed [DOT_W-1:0] f;
        logic signed [DOT_W-1:0] c;
        logic signed [DOT_W-1:0] b;
        logic                    adeg;
        logic                    edeg;
    } t_job;

    // Context carried through the second divider
    typedef struct packed {
        logic [2:0][CW-1:0] ps;
        logic [2:0][DV-1:0] r;
        logic [2:0][DV-1:0] d1;
        logic [2:0][DV-1:0] d2;
        logic               both;
        logic               q_is_t;  // quotient is t, fix holds s
        logic [PF:0]        fix;     // the parameter not produced by the divider
    } t_fin;

endpackage

// ===== rtl/scp_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
module scp_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int AL = AW / 2;
    localparam int BL = BW / 2;
    localparam int PW = AW + BW;

    logic signed [AL:0]      a_lo;
    logic signed [AW-AL-1:0] a_hi;
    logic signed [BL:0]      b_lo;
    logic signed [BW-BL-1:0] b_hi;

    logic signed [AL+BL+1:0]           r_ll;
    logic signed [AL+1+BW-BL-1:0]      r_lh;
    logic signed [AW-AL+BL:0]          r_hl;
    logic signed [AW-AL+BW-BL-1:0]     r_hh;

    assign a_lo = $signed({1'b0, i_a[AL-1:0]});
    assign a_hi = i_a[AW-1:AL];
    assign b_lo = $signed({1'b0, i_b[BL-1:0]});
    assign b_hi = i_b[BW-1:BL];

    // Form partial products, then align and sum them
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= a_lo * b_lo;
            r_lh <= a_lo * b_hi;
            r_hl <= a_hi * b_lo;
            r_hh <= a_hi * b_hi;
            o_p  <= (PW'(r_hh) <<< (AL + BL)) + (PW'(r_hl) <<< AL)
                  + (PW'(r_lh) <<< BL) + PW'(r_ll);
        end
    end
endmodule

// ===== rtl/scp_div.sv =====
// Pipelined restoring divider giving a clamped fraction num/den in [0, 1].
module scp_div #(
    parameter int W  = 8,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [W-1:0]  i_num,
    input  logic signed [W-1:0]  i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_vld,
    output logic [scp_pkg::PF:0] o_q,
    output logic [SW-1:0]        o_side
);
    import scp_pkg::*;

    logic          r_vld  [0:PF];
    logic          r_done [0:PF];
    logic [W-2:0]  r_rem  [0:PF];
    logic [W-2:0]  r_den  [0:PF];
    logic [PF:0]   r_q    [0:PF];
    logic [SW-1:0] r_side [0:PF];

    // Entry: settle the clamped cases, load the remainder otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den[W-2:0];
            r_rem[0]  <= i_num[W-2:0];
            if (i_num[W-1] || i_num == '0) begin
                r_done[0] <= 1'b1;
                r_q[0]    <= '0;
            end else if (i_num >= i_den) begin
                r_done[0] <= 1'b1;
                r_q[0]    <= PAR_ONE;
            end else begin
                r_done[0] <= 1'b0;
                r_q[0]    <= '0;
            end
        end
    end

    // One quotient bit per stage
    for (genvar g = 1; g <= PF; g++) begin : g_stage
        logic [W-1:0] rem2;
        logic [W-1:0] diff;
        logic         take;

        assign rem2 = {r_rem[g-1], 1'b0};
        assign diff = rem2 - {1'b0, r_den[g-1]};
        assign take = !diff[W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
            if (i_en) begin
                r_side[g] <= r_side[g-1];
                r_den[g]  <= r_den[g-1];
                r_done[g] <= r_done[g-1];
                if (r_done[g-1]) begin
                    r_rem[g] <= r_rem[g-1];
                    r_q[g]   <= r_q[g-1];
                end else begin
                    r_rem[g] <= take ? diff[W-2:0] : rem2[W-2:0];
                    r_q[g]   <= {r_q[g-1][PF-1:0], take};
                end
            end
        end
    end

    assign o_vld  = r_vld[PF];
    assign o_q    = r_q[PF];
    assign o_side = r_side[PF];
endmodule

// ===== rtl/scp_front.sv =====
// Front part: differences, dot products and point classification of a segment pair.
module scp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [scp_pkg::THR_W-1:0] i_thr,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  scp_pkg::t_seg_in      i_in_data,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output scp_pkg::t_job         o_job
);
    import scp_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3;

    logic signed [CW-1:0] ps [3];
    logic signed [CW-1:0] pe [3];
    logic signed [CW-1:0] qs [3];
    logic signed [CW-1:0] qe [3];

    logic signed [DV-1:0] r_d1 [3];
    logic signed [DV-1:0] r_d2 [3];
    logic signed [DV-1:0] r_r  [3];
    logic [CW-1:0]        r_ps [3];
    logic signed [DV-1:0] r2_d1 [3];
    logic signed [DV-1:0] r2_d2 [3];
    logic signed [DV-1:0] r2_r  [3];
    logic [CW-1:0]        r2_ps [3];

    logic signed [2*DV-1:0] r_paa [3];
    logic signed [2*DV-1:0] r_pee [3];
    logic signed [2*DV-1:0] r_pf  [3];
    logic signed [2*DV-1:0] r_pc  [3];
    logic signed [2*DV-1:0] r_pb  [3];

    logic signed [DOT_W-1:0] n_a, n_e, n_f, n_c, n_b, thr;

    assign en          = !r_v3 || i_job_ready;
    assign o_in_ready  = en;
    assign o_job_valid = r_v3;

    assign ps[0] = i_in_data.p_start_x;
    assign ps[1] = i_in_data.p_start_y;
    assign ps[2] = i_in_data.p_start_z;
    assign pe[0] = i_in_data.p_end_x;
    assign pe[1] = i_in_data.p_end_y;
    assign pe[2] = i_in_data.p_end_z;
    assign qs[0] = i_in_data.q_start_x;
    assign qs[1] = i_in_data.q_start_y;
    assign qs[2] = i_in_data.q_start_z;
    assign qe[0] = i_in_data.q_end_x;
    assign qe[1] = i_in_data.q_end_y;
    assign qe[2] = i_in_data.q_end_z;

    // Advance the valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Per axis: differences, then the five products
    for (genvar k = 0; k < 3; k++) begin : g_axis
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d1[k]  <= {pe[k][CW-1], pe[k]} - {ps[k][CW-1], ps[k]};
                r_d2[k]  <= {qe[k][CW-1], qe[k]} - {qs[k][CW-1], qs[k]};
                r_r[k]   <= {ps[k][CW-1], ps[k]} - {qs[k][CW-1], qs[k]};
                r_ps[k]  <= ps[k];
                r_paa[k] <= r_d1[k] * r_d1[k];
                r_pee[k] <= r_d2[k] * r_d2[k];
                r_pf[k]  <= r_d2[k] * r_r[k];
                r_pc[k]  <= r_d1[k] * r_r[k];
                r_pb[k]  <= r_d1[k] * r_d2[k];
                r2_d1[k] <= r_d1[k];
                r2_d2[k] <= r_d2[k];
                r2_r[k]  <= r_r[k];
                r2_ps[k] <= r_ps[k];
            end
        end
    end

    // Sum the products over the axes
    always_comb begin
        n_a = DOT_W'(r_paa[0]) + DOT_W'(r_paa[1]) + DOT_W'(r_paa[2]);
        n_e = DOT_W'(r_pee[0]) + DOT_W'(r_pee[1]) + DOT_W'(r_pee[2]);
        n_f = DOT_W'(r_pf[0]) + DOT_W'(r_pf[1]) + DOT_W'(r_pf[2]);
        n_c = DOT_W'(r_pc[0]) + DOT_W'(r_pc[1]) + DOT_W'(r_pc[2]);
        n_b = DOT_W'(r_pb[0]) + DOT_W'(r_pb[1]) + DOT_W'(r_pb[2]);
        thr = $signed({{(DOT_W-THR_W){1'b0}}, i_thr});
    end

    // Classify short segments as points
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                o_job.d1[k] <= r2_d1[k];
                o_job.d2[k] <= r2_d2[k];
                o_job.r[k]  <= r2_r[k];
                o_job.ps[k] <= r2_ps[k];
            end
            o_job.a    <= n_a;
            o_job.e    <= n_e;
            o_job.f    <= n_f;
            o_job.c    <= n_c;
            o_job.b    <= n_b;
            o_job.adeg <= n_a <= thr;
            o_job.edeg <= n_e <= thr;
        end
    end
endmodule

// ===== rtl/scp_fifo.sv =====
// Short request queue between the front and back parts.
module scp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  scp_pkg::t_job i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output scp_pkg::t_job o_out_data
);
    import scp_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign o_in_ready  = r_cnt != (AW+1)'(DEPTH);
    assign o_out_valid = r_cnt != '0;
    assign o_out_data  = r_mem[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    // Store a request
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/scp_back.sv =====
// Back part: solve for the segment parameters and form the saturated difference.
module scp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  scp_pkg::t_job     i_job,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output scp_pkg::t_seg_out o_out_data
);
    import scp_pkg::*;

    localparam int SH_W = ACC_W - PF;
    localparam int MW   = DOT_W + PF + 2;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    t_job r_j1, r_j2, r_j3, r_j4, r_j5;
    t_fin r_f6, r_f7, r_f8;

    logic signed [2*DOT_W-1:0] p_ae, p_bb, p_bf, p_ce;
    logic signed [WA-1:0]      n_dena, n_numa, r_dena, r_numa;

    logic                      va;
    logic [PF:0]               sa;
    logic [$bits(t_job)-1:0]   ja_bits;
    t_job                      ja;
    logic [PF:0]               r_s4, r_s5;
    logic signed [MW-1:0]      p_bs;

    logic signed [WB-1:0] tn, ed, n_numb, n_denb, r_numb, r_denb;
    t_fin                 n_fin;

    logic                    vb;
    logic [PF:0]             qb;
    logic [$bits(t_fin)-1:0] fb_bits;
    t_fin                    fb;
    logic [PF:0]             s_fin, t_fin_v;

    logic signed [DV+PF+1:0] p_ds [3];
    logic signed [DV+PF+1:0] p_dt [3];
    logic signed [CW-1:0]    n_diff [3];

    assign en          = !o_out_valid || i_out_ready;
    assign o_job_ready = en;

    // Advance valid flags of the stages outside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_v8        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_job_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= va;
            r_v5        <= r_v4;
            r_v6        <= r_v5;
            r_v7        <= vb;
            r_v8        <= r_v7;
            o_out_valid <= r_v8;
        end
    end

    // Wide products for the determinant and the s numerator
    scp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ae (
        .i_clk(i_clk), .i_en(en), .i_a(i_job.a), .i_b(i_job.e), .o_p(p_ae));
    scp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bb (
        .i_clk(i_clk), .i_en(en), .i_a(i_job.b), .i_b(i_job.b), .o_p(p_bb));
    scp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_bf (
        .i_clk(i_clk), .i_en(en), .i_a(i_job.b), .i_b(i_job.f), .o_p(p_bf));
    scp_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_ce (
        .i_clk(i_clk), .i_en(en), .i_a(i_job.c), .i_b(i_job.e), .o_p(p_ce));

    // Pick the first division: s for the general case, zero otherwise
    always_comb begin
        n_dena = WA'(p_ae) - WA'(p_bb);
        n_numa = WA'(p_bf) - WA'(p_ce);
        if (r_j2.adeg || r_j2.edeg || n_dena == '0) begin
            n_numa = '0;
            n_dena = WA'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j1   <= i_job;
            r_j2   <= r_j1;
            r_j3   <= r_j2;
            r_numa <= n_numa;
            r_dena <= n_dena;
        end
    end

    scp_div #(.W(WA), .SW($bits(t_job))) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_v3),
        .i_num(r_numa), .i_den(r_dena), .i_side(r_j3),
        .o_vld(va), .o_q(sa), .o_side(ja_bits));

    assign ja = t_job'(ja_bits);

    // b * s for the t numerator
    scp_mul #(.AW(DOT_W), .BW(PF+2)) u_mul_bs (
        .i_clk(i_clk), .i_en(en), .i_a(ja.b), .i_b($signed({1'b0, sa})), .o_p(p_bs));

    // Pick the second division by case and by where t falls
    always_comb begin
        tn = WB'(p_bs) + (WB'(r_j5.f) <<< PF);
        ed = WB'(r_j5.e) <<< PF;
        n_fin.ps     = r_j5.ps;
        n_fin.r      = r_j5.r;
        n_fin.d1     = r_j5.d1;
        n_fin.d2     = r_j5.d2;
        n_fin.both   = r_j5.adeg && r_j5.edeg;
        n_fin.q_is_t = 1'b0;
        n_fin.fix    = '0;
        n_numb       = -WB'(r_j5.c);
        n_denb       = WB'(r_j5.a);
        if (r_j5.adeg && r_j5.edeg) begin
            n_numb = '0;
            n_denb = WB'(1);
        end else if (r_j5.adeg) begin
            n_numb       = WB'(r_j5.f);
            n_denb       = WB'(r_j5.e);
            n_fin.q_is_t = 1'b1;
        end else if (!r_j5.edeg) begin
            if (tn[WB-1]) begin
                n_fin.fix = '0;
            end else if (tn > ed) begin
                n_numb    = WB'(r_j5.b) - WB'(r_j5.c);
                n_fin.fix = PAR_ONE;
            end else begin
                n_numb       = tn;
                n_denb       = ed;
                n_fin.q_is_t = 1'b1;
                n_fin.fix    = r_s5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j4   <= ja;
            r_j5   <= r_j4;
            r_s4   <= sa;
            r_s5   <= r_s4;
            r_f6   <= n_fin;
            r_numb <= n_numb;
            r_denb <= n_denb;
        end
    end

    scp_div #(.W(WB), .SW($bits(t_fin))) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_v6),
        .i_num(r_numb), .i_den(r_denb), .i_side(r_f6),
        .o_vld(vb), .o_q(qb), .o_side(fb_bits));

    assign fb      = t_fin'(fb_bits);
    assign s_fin   = fb.q_is_t ? fb.fix : qb;
    assign t_fin_v = fb.q_is_t ? qb : fb.fix;

    // Scale the direction vectors by s and t
    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [ACC_W-1:0] acc;
        logic [SH_W-1:0]         sh;

        scp_mul #(.AW(DV), .BW(PF+2)) u_mul_ds (
            .i_clk(i_clk), .i_en(en), .i_a($signed(fb.d1[k])),
            .i_b($signed({1'b0, s_fin})), .o_p(p_ds[k]));
        scp_mul #(.AW(DV), .BW(PF+2)) u_mul_dt (
            .i_clk(i_clk), .i_en(en), .i_a($signed(fb.d2[k])),
            .i_b($signed({1'b0, t_fin_v})), .o_p(p_dt[k]));

        // Round to nearest and saturate, or pass P's start when both are points
        always_comb begin
            acc = (ACC_W'($signed(r_f8.r[k])) <<< PF) + ACC_W'(p_ds[k]) - ACC_W'(p_dt[k])
                + (ACC_W'(1) <<< (PF - 1));
            sh  = acc[ACC_W-1:PF];
            if (&sh[SH_W-1:CW-1] || !(|sh[SH_W-1:CW-1])) begin
                n_diff[k] = sh[CW-1:0];
            end else if (sh[SH_W-1]) begin
                n_diff[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_diff[k] = {1'b0, {(CW-1){1'b1}}};
            end
            if (r_f8.both) begin
                n_diff[k] = r_f8.ps[k];
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f7                       <= fb;
            r_f8                       <= r_f7;
            o_out_data.diff_x          <= n_diff[0];
            o_out_data.diff_y          <= n_diff[1];
            o_out_data.diff_z          <= n_diff[2];
            o_out_data.both_degenerate <= r_f8.both;
        end
    end
endmodule

// ===== rtl/segment_closest_points_unit.sv =====
// Top level of the segment closest points unit: configuration register and part wiring.
//
// Takes one pair of 3D segments per request (signed Q16.16 endpoints) and returns the vector
// from the closest point on Q to the closest point on P, rounded and saturated to Q16.16.
// A segment whose squared length is at or below degenerate_threshold counts as a point; when
// both are points the result is P's start point and both_degenerate is set. The unit accepts
// a new pair every cycle as long as results are taken, and keeps up to 82 pairs in flight.
// From accept to result a pair passes the front part, the queue and the back part, whose depth
// is set mostly by the two 33-stage pipelined dividers that solve for s and then t.
// The threshold resets to 1 and should be written only while the unit is empty.
module segment_closest_points_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [scp_pkg::THR_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  scp_pkg::t_seg_in          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output scp_pkg::t_seg_out         o_out_data
);
    import scp_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic             job_valid, job_ready, q_valid, q_ready;
    t_job             job, q_job;

    assign o_cfg_ready = 1'b1;

    // Hold the degenerate threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_W'(1);
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    scp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_thr(r_thr),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job));

    scp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(job_valid), .o_in_ready(job_ready), .i_in_data(job),
        .o_out_valid(q_valid), .i_out_ready(q_ready), .o_out_data(q_job));

    scp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job(q_job),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data));
endmodule
